// ===== hw/rtl/mlsl_pkg.sv =====
// shared opcodes, codes, status types and fixed-point helpers of the steering law
package mlsl_pkg;

	// datapath operations issued by the controller
	localparam logic [3:0] OP_NONE  = 4'd0;
	localparam logic [3:0] OP_LOAD  = 4'd1;
	localparam logic [3:0] OP_DIV1  = 4'd2;
	localparam logic [3:0] OP_SEL   = 4'd3;
	localparam logic [3:0] OP_DIV2  = 4'd4;
	localparam logic [3:0] OP_SIGN2 = 4'd5;
	localparam logic [3:0] OP_THIRD = 4'd6;
	localparam logic [3:0] OP_HALF  = 4'd7;
	localparam logic [3:0] OP_BAND3 = 4'd8;
	localparam logic [3:0] OP_FIN   = 4'd9;
	localparam logic [3:0] OP_OUT   = 4'd10;

	// outcome codes
	localparam logic [1:0] OC_NORMAL = 2'd0;
	localparam logic [1:0] OC_TURN   = 2'd1;
	localparam logic [1:0] OC_LOST   = 2'd2;

	// quadrant codes
	localparam logic [2:0] Q_CENTER = 3'd0;
	localparam logic [2:0] Q_ONE    = 3'd1;
	localparam logic [2:0] Q_TWO    = 3'd2;
	localparam logic [2:0] Q_THREE  = 3'd3;
	localparam logic [2:0] Q_FOUR   = 3'd4;
	localparam logic [2:0] Q_LOST   = 3'd5;

	// speed constants in Q.15, held in 19-bit signed working width
	localparam logic signed [18:0] SPD_0P5   = 19'sd16384;
	localparam logic signed [18:0] SPD_0P1   = 19'sd3277;
	localparam logic signed [18:0] CLAMP_0P6 = 19'sd19660;

	// thresholds
	localparam logic [17:0] GT_0P2  = 18'd6553;
	localparam logic [17:0] GT_0P1  = 18'd3276;
	localparam logic [17:0] GT_0P03 = 18'd983;
	localparam logic [16:0] GE_0P1  = 17'd3277;
	localparam logic [15:0] DIST_0P5 = 16'd2048;
	localparam logic [15:0] DIST_0P3 = 16'd1229;
	localparam logic [15:0] DIST_0P2 = 16'd820;

	// reciprocals ceil(2^35 / d): floor(x * 2^15 / d) = (x * rcp) >> 20 for 9-bit x
	localparam logic [29:0] RCP_50   = 30'd687194768;
	localparam logic [29:0] RCP_100  = 30'd343597384;
	localparam logic [29:0] RCP_200  = 30'd171798692;
	localparam logic [29:0] RCP_164  = 30'd209510600;
	localparam logic [29:0] RCP_1640 = 30'd20951060;

	typedef struct packed {
		logic [3:0] op;
	} dp_cmd_t;

	typedef struct packed {
		logic lost;
		logic div_busy;
		logic band1_go;
		logic need_div2;
		logic gt_0p2;
		logic band2_go;
		logic band3_go;
		logic halve_go;
		logic out_busy;
	} dp_stat_t;

	// floor(x / 5) by reciprocal, exact for 17-bit x
	function automatic logic [14:0] div5(input logic [16:0] x);
		logic [32:0] p;
		p = {16'd0, x} * 33'd52429;
		return p[32:18];
	endfunction

	// floor(x / 3) by reciprocal, exact for 17-bit x
	function automatic logic [15:0] div3(input logic [16:0] x);
		logic [32:0] p;
		p = {16'd0, x} * 33'd43691;
		return p[32:17];
	endfunction

endpackage

// ===== hw/rtl/mlsl_div.sv =====
// constant divider by reciprocal multiply: operands registered, then the quotient registered from their product
module mlsl_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [8:0]  num,
	input  logic [29:0] rcp,
	output logic        busy,
	output logic [23:0] quo
);
	logic [8:0]  num_q;
	logic [29:0] rcp_q;
	logic [23:0] quo_q;
	logic        busy_q;
	logic [38:0] prod;

	// product of the offset operand and the scaled reciprocal
	assign prod = {30'd0, num_q} * {9'd0, rcp_q};

	// busy for the one cycle between operand capture and quotient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) busy_q <= 1'b0;
		else busy_q <= start;
	end

	// operand and quotient registers
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rcp_q <= rcp;
		end
		if (busy_q) quo_q <= {5'd0, prod[38:20]};
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

// ===== hw/rtl/mlsl_dp.sv =====
// datapath: item registers, classification, steering arithmetic and result register
module mlsl_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mlsl_pkg::dp_cmd_t      cmd,
	output mlsl_pkg::dp_stat_t     stat,
	input  logic                   wide_mode,
	input  logic [7:0]             front_pos,
	input  logic [7:0]             back_pos,
	input  logic [7:0]             center_pos,
	input  logic [15:0]            goal_distance,
	input  logic signed [15:0]     linear_speed_in,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [15:0]     linear_speed_out,
	output logic signed [15:0]     angular_speed,
	output logic [2:0]             quadrant,
	output logic [1:0]             outcome
);
	import mlsl_pkg::*;

	logic [7:0]         f_q, b_q, c_q;
	logic [15:0]        dis_q;
	logic signed [15:0] als_q;
	logic signed [17:0] aas_q;
	logic [1:0]         oc_q;
	logic               out_valid_q;
	logic signed [15:0] lin_out_q, ang_out_q;
	logic [2:0]         quad_out_q;
	logic [1:0]         oc_out_q;

	logic [7:0]  up, down, diff, v1, v2;
	logic [8:0]  dsum;
	logic [2:0]  q_w;
	logic        div_start, div_busy;
	logic [8:0]  div_num;
	logic [23:0] div_quo;
	logic [29:0] div_rcp;

	// offsets from the centered position
	always_comb begin
		up   = (f_q > c_q) ? 8'(f_q - c_q) : 8'(c_q - f_q);
		down = (b_q > c_q) ? 8'(b_q - c_q) : 8'(c_q - b_q);
		diff = (up > down) ? 8'(up - down) : 8'(down - up);
		dsum = {1'b0, up} + {1'b0, down};
		v1   = wide_mode ? 8'd30 : 8'd5;
		v2   = wide_mode ? 8'd12 : 8'd2;
	end

	// quadrant classification
	always_comb begin
		if (up > down) q_w = (f_q > c_q) ? Q_TWO : Q_ONE;
		else if (down > up) q_w = (b_q > c_q) ? Q_FOUR : Q_THREE;
		else if (b_q == f_q) q_w = (b_q > c_q) ? Q_TWO : ((b_q < c_q) ? Q_ONE : Q_CENTER);
		else q_w = Q_CENTER;
		if (f_q == 8'd0 || b_q == 8'd0) q_w = Q_LOST;
	end

	// divider operands: gain quotient, then the turn-back rescale
	always_comb begin
		div_start = (cmd.op == OP_DIV1) || (cmd.op == OP_DIV2);
		if (cmd.op == OP_DIV2) begin
			div_num = {1'b0, down};
			div_rcp = aas_q[17] ? RCP_1640 : RCP_164;
		end else if (q_w == Q_CENTER) begin
			div_num = {1'b0, up};
			div_rcp = wide_mode ? RCP_100 : RCP_50;
		end else begin
			div_num = dsum;
			div_rcp = wide_mode ? RCP_200 : RCP_100;
		end
	end

	mlsl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.rcp    (div_rcp),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	// magnitudes and truncating helpers
	logic [17:0]        aas_mag, aas_hm;
	logic [16:0]        als_mag;
	logic signed [17:0] aas_half, aas_third;
	logic [15:0]        third_m;
	logic [14:0]        als5_m;
	logic signed [15:0] als_div5, als_dbl;
	logic signed [16:0] dbl_w;

	always_comb begin
		aas_mag   = aas_q[17] ? 18'(-aas_q) : 18'(aas_q);
		als_mag   = als_q[15] ? 17'(-{als_q[15], als_q}) : {1'b0, als_q};
		aas_hm    = {1'b0, aas_mag[17:1]};
		aas_half  = aas_q[17] ? -$signed(aas_hm) : $signed(aas_hm);
		third_m   = div3({aas_mag[15:0], 1'b0});
		aas_third = aas_q[17] ? -$signed({2'b00, third_m}) : $signed({2'b00, third_m});
		als5_m    = div5(als_mag);
		als_div5  = als_q[15] ? -$signed({1'b0, als5_m}) : $signed({1'b0, als5_m});
		dbl_w     = {als_q, 1'b0};
		if (dbl_w > 17'sd32767) als_dbl = 16'sh7fff;
		else if (dbl_w < -17'sd32768) als_dbl = 16'sh8000;
		else als_dbl = dbl_w[15:0];
	end

	// steering case selection and clamp
	logic signed [18:0] m, m2, m6, sel_aas, clamp_aas;
	logic [16:0]        m_a, m_b3;
	logic [14:0]        m_b;
	logic signed [15:0] sel_als;
	logic [1:0]         sel_oc;
	logic [2:0]         side;

	always_comb begin
		m    = $signed({1'b0, div_quo[17:0]});
		m_a  = (div_quo > 24'd98304) ? 17'd98304 : div_quo[16:0];
		m_b  = (div_quo > 24'd32767) ? 15'd32767 : div_quo[14:0];
		m_b3 = {2'b00, m_b} + {1'b0, m_b, 1'b0};
		m2   = $signed({4'd0, div5(m_a)});
		m6   = $signed({4'd0, div5(m_b3)});

		if (f_q == 8'd0) side = 3'd3;
		else if (b_q == 8'd0) side = 3'd4;
		else if (f_q > c_q && b_q > c_q) side = 3'd1;
		else if (f_q < c_q && b_q < c_q) side = 3'd2;
		else side = 3'd0;

		sel_als = als_q;
		sel_oc  = OC_NORMAL;
		sel_aas = 19'sd0;
		if (q_w == Q_CENTER) begin
			if (!(b_q == f_q && b_q == c_q)) begin
				sel_als = als_div5;
				sel_aas = (f_q > c_q) ? -m : m;
			end
		end else begin
			unique case (side)
				3'd1: begin
					if (q_w == Q_TWO) sel_aas = als_q[15] ? -m : ((diff > v1) ? -m2 : m6);
					else if (q_w == Q_FOUR) sel_aas = als_q[15] ? ((diff > v1) ? m2 : -m6) : m;
					else sel_aas = m;
				end
				3'd2: begin
					if (q_w == Q_ONE) sel_aas = als_q[15] ? m : ((diff > v1) ? m2 : -m6);
					else if (q_w == Q_THREE) sel_aas = als_q[15] ? ((diff > v1) ? -m2 : m6) : -m;
					else sel_aas = m;
				end
				3'd3: begin
					if (als_q > 16'sd0) begin
						if (b_q > c_q) sel_aas = SPD_0P1;
						else sel_aas = (b_q < c_q) ? -SPD_0P1 : 19'sd0;
					end else begin
						sel_aas = (b_q > c_q) ? -SPD_0P5 : SPD_0P5;
						sel_als = als_dbl;
						sel_oc  = OC_TURN;
					end
				end
				3'd4: begin
					if (als_q > 16'sd0) begin
						sel_aas = (f_q > c_q) ? SPD_0P5 : -SPD_0P5;
						sel_als = als_dbl;
						sel_oc  = OC_TURN;
					end else begin
						if (f_q > c_q) sel_aas = -SPD_0P1;
						else sel_aas = (f_q < c_q) ? SPD_0P1 : 19'sd0;
					end
				end
				default: sel_aas = (q_w == Q_TWO || q_w == Q_THREE) ? -m : m;
			endcase
		end

		if (sel_aas > CLAMP_0P6) clamp_aas = CLAMP_0P6;
		else if (sel_aas < -CLAMP_0P6) clamp_aas = -CLAMP_0P6;
		else clamp_aas = sel_aas;
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				f_q   <= front_pos;
				b_q   <= back_pos;
				c_q   <= center_pos;
				dis_q <= goal_distance;
				aas_q <= 18'sd0;
				if (front_pos == 8'd0 && back_pos == 8'd0) begin
					als_q <= 16'sd0;
					oc_q  <= OC_LOST;
				end else begin
					als_q <= linear_speed_in;
					oc_q  <= OC_NORMAL;
				end
			end
			OP_SEL: begin
				aas_q <= clamp_aas[17:0];
				als_q <= sel_als;
				oc_q  <= sel_oc;
			end
			OP_SIGN2: begin
				aas_q <= aas_q[17] ? -$signed({1'b0, div_quo[16:0]})
				                   : $signed({1'b0, div_quo[16:0]});
			end
			OP_THIRD: aas_q <= aas_third;
			OP_HALF:  aas_q <= aas_half;
			OP_BAND3: begin
				if (als_mag >= GE_0P1) als_q <= als_div5;
				if (q_w == Q_LOST) aas_q <= 18'sd0;
			end
			OP_FIN: begin
				if (diff < v2 && aas_mag > GT_0P03) aas_q <= aas_half;
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) begin
			lin_out_q  <= als_q;
			ang_out_q  <= aas_q[15:0];
			quad_out_q <= q_w;
			oc_out_q   <= oc_q;
		end
	end

	// status back to the controller
	always_comb begin
		stat.lost      = (f_q == 8'd0) && (b_q == 8'd0);
		stat.div_busy  = div_busy;
		stat.band1_go  = (dis_q < DIST_0P5) && (aas_mag > GT_0P2);
		stat.need_div2 = (oc_q == OC_TURN);
		stat.gt_0p2    = aas_mag > GT_0P2;
		stat.band2_go  = (dis_q < DIST_0P3) && (aas_mag > GT_0P1);
		stat.band3_go  = dis_q < DIST_0P2;
		stat.halve_go  = (q_w != Q_LOST) && (als_q != 16'sd0) && (aas_mag > {1'b0, als_mag});
		stat.out_busy  = out_valid_q && out_stall;
	end

	assign out_valid        = out_valid_q;
	assign linear_speed_out = lin_out_q;
	assign angular_speed    = ang_out_q;
	assign quadrant         = quad_out_q;
	assign outcome          = oc_out_q;

endmodule

// ===== hw/rtl/mlsl_ctrl.sv =====
// controller: sequences divide, case selection and the distance-band loops
module mlsl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mlsl_pkg::dp_stat_t  stat,
	output mlsl_pkg::dp_cmd_t   cmd
);
	import mlsl_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DIV1S = 4'd1;
	localparam logic [3:0] S_DIVW1 = 4'd2;
	localparam logic [3:0] S_SEL   = 4'd3;
	localparam logic [3:0] S_B1    = 4'd4;
	localparam logic [3:0] S_DIVW2 = 4'd5;
	localparam logic [3:0] S_SG2   = 4'd6;
	localparam logic [3:0] S_L23   = 4'd7;
	localparam logic [3:0] S_B2    = 4'd8;
	localparam logic [3:0] S_B3    = 4'd9;
	localparam logic [3:0] S_LH    = 4'd10;
	localparam logic [3:0] S_FIN   = 4'd11;
	localparam logic [3:0] S_DONE  = 4'd12;

	logic [3:0] state_q, state_d;

	// next state and datapath command
	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DIV1S;
				end
			end
			S_DIV1S: begin
				if (stat.lost) begin
					state_d = S_DONE;
				end else begin
					cmd.op  = OP_DIV1;
					state_d = S_DIVW1;
				end
			end
			S_DIVW1: if (!stat.div_busy) state_d = S_SEL;
			S_SEL: begin
				cmd.op  = OP_SEL;
				state_d = S_B1;
			end
			S_B1: begin
				if (!stat.band1_go) begin
					state_d = S_B2;
				end else if (stat.need_div2) begin
					cmd.op  = OP_DIV2;
					state_d = S_DIVW2;
				end else begin
					state_d = S_L23;
				end
			end
			S_DIVW2: if (!stat.div_busy) state_d = S_SG2;
			S_SG2: begin
				cmd.op  = OP_SIGN2;
				state_d = S_L23;
			end
			S_L23: begin
				if (stat.gt_0p2) cmd.op = OP_THIRD;
				else state_d = S_B2;
			end
			S_B2: begin
				if (stat.band2_go) cmd.op = OP_HALF;
				else state_d = S_B3;
			end
			S_B3: begin
				if (stat.band3_go) begin
					cmd.op  = OP_BAND3;
					state_d = S_LH;
				end else begin
					state_d = S_DONE;
				end
			end
			S_LH: begin
				if (stat.halve_go) cmd.op = OP_HALF;
				else state_d = S_FIN;
			end
			S_FIN: begin
				cmd.op  = OP_FIN;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign in_stall = state_q != S_IDLE;

endmodule

// ===== hw/rtl/magnetic_line_steering_law.sv =====
// top level of the magnetic line steering law: register port, controller and datapath
//
// channel   direction  handshake            payload
// input     in         in_valid / in_stall  front_pos back_pos center_pos goal_distance
//                                           linear_speed_in
// result    out        out_valid / out_stall linear_speed_out angular_speed quadrant outcome
// register  in/out     psel penable pwrite  paddr pwdata prdata pready
//
// an item with both lines lost goes from load straight to its result; otherwise the gain and
// turn-back divides are reciprocal multiplies, and each divide-down step repeats its loop state
// reset clears the mode register to narrow-sensor gains and returns the controller to idle
// in_stall is high from the cycle after a request is taken until its result is registered
// a stalled result holds in the output register while the next request is processed
module magnetic_line_steering_law (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         front_pos,
	input  logic [7:0]         back_pos,
	input  logic [7:0]         center_pos,
	input  logic [15:0]        goal_distance,
	input  logic signed [15:0] linear_speed_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] linear_speed_out,
	output logic signed [15:0] angular_speed,
	output logic [2:0]         quadrant,
	output logic [1:0]         outcome
);
	import mlsl_pkg::*;

	logic     mode_q;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= 1'b0;
		else if (psel && penable && pwrite && !paddr[2]) mode_q <= pwdata[0];
	end

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {31'd0, mode_q};

	mlsl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	mlsl_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.wide_mode        (mode_q),
		.front_pos        (front_pos),
		.back_pos         (back_pos),
		.center_pos       (center_pos),
		.goal_distance    (goal_distance),
		.linear_speed_in  (linear_speed_in),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.linear_speed_out (linear_speed_out),
		.angular_speed    (angular_speed),
		.quadrant         (quadrant),
		.outcome          (outcome)
	);

`ifndef NO_ASSERTIONS
	// a taken request keeps the input side closed while it is worked on
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a request");

	// lost line gives zero speeds and the lost quadrant
	a_lost_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outcome == OC_LOST |->
		linear_speed_out == 16'sd0 && angular_speed == 16'sd0 && quadrant == Q_LOST)
		else $error("lost line result not zeroed");

	// angular speed stays inside the clamp
	a_ang_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> angular_speed <= 16'sd19660 && angular_speed >= -16'sd19660)
		else $error("angular speed beyond clamp");

	// a turn advice only comes with a sensor lost on one side
	a_turn_quad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outcome == OC_TURN |-> quadrant == Q_LOST)
		else $error("turn advice without one-side loss");
`endif

endmodule

// ===== sim/magnetic_line_steering_law_tb.sv =====
// testbench of the magnetic line steering law: random and directed requests checked by a scoreboard
module magnetic_line_steering_law_tb;
	import mlsl_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic signed [15:0] lin;
		logic signed [15:0] ang;
		logic [2:0]         quad;
		logic [1:0]         oc;
	} steer_t;

	// scoreboard: holds predicted steering results and compares them
	class steer_board;
		steer_t pending[$];
		int     mismatches;
		bit     wide;

		function int mag(int v);
			return v < 0 ? -v : v;
		endfunction

		function int sat(int v);
			if (v > 32767) return 32767;
			if (v < -32768) return -32768;
			return v;
		endfunction

		function void note_request(logic [7:0] fp, logic [7:0] bp, logic [7:0] cp,
				logic [15:0] gdist, logic signed [15:0] lin_in);
			int f, b, c, d, lin, ang, mu, v1, v2, up, dn, diff, dsum, q, side, oc, m, m2, m6, t;
			steer_t r;
			f = fp; b = bp; c = cp; d = gdist; lin = lin_in; ang = 0;
			mu = wide ? 100 : 50; v1 = wide ? 30 : 5; v2 = wide ? 12 : 2;
			up = mag(f - c); dn = mag(b - c); diff = mag(up - dn); dsum = up + dn;
			side = 0; oc = OC_NORMAL;
			if (up > dn) q = f > c ? Q_TWO : Q_ONE;
			else if (dn > up) q = b > c ? Q_FOUR : Q_THREE;
			else if (b == f) q = b > c ? Q_TWO : (b < c ? Q_ONE : Q_CENTER);
			else q = Q_CENTER;
			if (f == 0 || b == 0) q = Q_LOST;
			if (f == 0 && b == 0) begin
				lin = 0; ang = 0; oc = OC_LOST;
			end else begin
				if (q == Q_CENTER) begin
					if (!(b == f && b == c)) begin
						lin = lin / 5;
						ang = (up * 32768) / mu;
						if (f > c) ang = -ang;
					end
				end else begin
					m = (dsum * 32768) / (2 * mu); m2 = m * 2 / 10; m6 = m * 6 / 10;
					ang = m;
					if (f > c && b > c) side = 1;
					if (f < c && b < c && f != 0 && b != 0) side = 2;
					if (f == 0) side = 3;
					if (b == 0) side = 4;
					case (side)
						0: ang = (q == Q_TWO || q == Q_THREE) ? -m : m;
						1: begin
							if (q == Q_TWO) ang = lin < 0 ? -m : (diff > v1 ? -m2 : m6);
							else if (q == Q_FOUR) ang = lin < 0 ? (diff > v1 ? m2 : -m6) : m;
						end
						2: begin
							if (q == Q_ONE) ang = lin < 0 ? m : (diff > v1 ? m2 : -m6);
							else if (q == Q_THREE) ang = lin < 0 ? (diff > v1 ? -m2 : m6) : -m;
						end
						3: begin
							if (lin > 0) ang = b > c ? 3277 : (b < c ? -3277 : 0);
							else begin
								ang = b > c ? -16384 : 16384; lin = sat(lin * 2); oc = OC_TURN;
							end
						end
						default: begin
							if (lin > 0) begin
								ang = f > c ? 16384 : -16384; lin = sat(lin * 2); oc = OC_TURN;
							end else ang = f > c ? -3277 : (f < c ? 3277 : 0);
						end
					endcase
				end
				if (ang > 19660) ang = 19660;
				if (ang < -19660) ang = -19660;
				// distance bands
				if (d < 2048 && mag(ang) > 6553) begin
					if (oc == OC_TURN) begin
						t = (dn * 32768) / 164;
						if (ang < 0) ang = -((dn * 32768) / 1640);
						else if (ang > 0) ang = t;
					end
					while (mag(ang) > 6553) ang = ang * 2 / 3;
				end
				if (d < 1229)
					while (mag(ang) > 3276) ang = ang / 2;
				if (d < 820) begin
					if (mag(lin) >= 3277) lin = lin / 5;
					if (q == Q_LOST) ang = 0;
					else if (lin != 0)
						while (mag(ang) > mag(lin)) ang = ang / 2;
					if (diff < v2 && mag(ang) > 983) ang = ang / 2;
				end
			end
			r.lin = 16'(lin); r.ang = 16'(ang); r.quad = 3'(q); r.oc = 2'(oc);
			pending.push_back(r);
		endfunction

		function void check_result(steer_t got);
			steer_t exp_r;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
				return;
			end
			exp_r = pending.pop_front();
			if (got !== exp_r) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected lin %0d ang %0d q %0d oc %0d, %s %0d %s %0d",
						exp_r.lin, exp_r.ang, exp_r.quad, exp_r.oc,
						"got lin", got.lin, "ang", got.ang);
				if (mismatches <= 10)
					$display("          got q %0d oc %0d", got.quad, got.oc);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [7:0] front_pos, back_pos, center_pos;
	logic [15:0] goal_distance;
	logic signed [15:0] linear_speed_in, linear_speed_out, angular_speed;
	logic [2:0] quadrant;
	logic [1:0] outcome;

	steer_board board;
	int idle_cycles = 0;
	bit sink_bursty = 1'b0;

	magnetic_line_steering_law uut (.*);

	// clock
	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// register write during idle
	task automatic write_mode(bit val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= 3'd0; pwdata <= {31'd0, val};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		board.wide = val;
	endtask

	// valid stays high into a zero gap, so the next request replaces the payload at once
	task automatic send_request(logic [7:0] fp, logic [7:0] bp, logic [7:0] cp,
			logic [15:0] gdist, logic [15:0] lin_in);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1; front_pos <= fp; back_pos <= bp; center_pos <= cp;
		goal_distance <= gdist; linear_speed_in <= lin_in;
		do @(posedge clk); while (in_stall);
		board.note_request(fp, bp, cp, gdist, lin_in);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	// random request, mostly with line positions near the center
	task automatic random_request();
		logic [7:0] c, fp, bp;
		logic [15:0] gdist;
		int r;
		c = 8'($urandom_range(0, 255));
		r = $urandom_range(0, 9);
		if (r < 6) begin
			fp = 8'(int'(c) + $urandom_range(0, 80) - 40);
			bp = 8'(int'(c) + $urandom_range(0, 80) - 40);
		end else begin
			fp = 8'($urandom); bp = 8'($urandom);
		end
		if ($urandom_range(0, 5) == 0) fp = 8'd0;
		if ($urandom_range(0, 5) == 0) bp = 8'd0;
		r = $urandom_range(0, 3);
		gdist = r == 0 ? 16'($urandom_range(0, 2100)) : 16'($urandom);
		send_request(fp, bp, c, gdist, 16'($urandom));
	endtask

	// result side
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result({linear_speed_out, angular_speed, quadrant, outcome});
		if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if ($urandom_range(0, 19) == 0) sink_bursty <= !sink_bursty;
		out_stall <= sink_bursty ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 9) < 2);
	end

	// watchdog
	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		board = new();
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0; front_pos = 0; back_pos = 0; center_pos = 0;
		goal_distance = 0; linear_speed_in = 0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: lost lines, centered, one side lost, extremes
		send_request(8'd0, 8'd0, 8'd128, 16'hFFFF, 16'sh7FFF);
		send_request(8'd128, 8'd128, 8'd128, 16'hFFFF, 16'sh1000);
		send_request(8'd130, 8'd130, 8'd128, 16'hFFFF, 16'sh1000);
		send_request(8'd140, 8'd120, 8'd128, 16'hFFFF, 16'sh1000);
		send_request(8'd0, 8'd200, 8'd100, 16'hFFFF, 16'sh7FFF);
		send_request(8'd0, 8'd200, 8'd100, 16'h0100, 16'sh8000);
		send_request(8'd0, 8'd50, 8'd100, 16'hFFFF, 16'sh8000);
		send_request(8'd0, 8'd100, 8'd100, 16'h0000, 16'sh0100);
		send_request(8'd200, 8'd0, 8'd100, 16'h0400, 16'sh7FFF);
		send_request(8'd50, 8'd0, 8'd100, 16'hFFFF, 16'sh7FFF);
		send_request(8'd100, 8'd0, 8'd100, 16'h0000, 16'sh8000);
		send_request(8'd255, 8'd255, 8'd0, 16'h0000, 16'sh7FFF);
		send_request(8'd150, 8'd140, 8'd128, 16'h04C0, 16'sh8000);
		send_request(8'd140, 8'd150, 8'd128, 16'h0300, 16'sh8000);
		send_request(8'd110, 8'd100, 8'd128, 16'h0300, 16'sh4000);
		send_request(8'd100, 8'd110, 8'd128, 16'h0700, 16'sh8001);
		send_request(8'd1, 8'd1, 8'd255, 16'h0000, 16'sh0000);
		send_request(8'd127, 8'd129, 8'd128, 16'h0000, 16'shFFFF);
		drain();
		write_mode(1);
		send_request(8'd255, 8'd1, 8'd128, 16'h0000, 16'sh7FFF);
		send_request(8'd160, 8'd140, 8'd128, 16'h0200, 16'sh8000);
		for (int i = 0; i < 200; i++) random_request();
		drain();
		write_mode(0);
		for (int i = 0; i < 200; i++) random_request();
		drain();
		write_mode(1);
		for (int i = 0; i < 50; i++) random_request();
		drain();
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
